@@ design/acrp_pkg.sv @@
package acrp_pkg;

    // parse phases
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_HEADER  = 4'd1;
    localparam logic [3:0] PH_SPS_HI  = 4'd2;
    localparam logic [3:0] PH_SPS_LO  = 4'd3;
    localparam logic [3:0] PH_SPS_PAY = 4'd4;
    localparam logic [3:0] PH_PPS_CNT = 4'd5;
    localparam logic [3:0] PH_PPS_HI  = 4'd6;
    localparam logic [3:0] PH_PPS_LO  = 4'd7;
    localparam logic [3:0] PH_PPS_PAY = 4'd8;
    localparam logic [3:0] PH_DONE    = 4'd9;

    // byte kinds
    localparam logic [2:0] KIND_HDR     = 3'd0;
    localparam logic [2:0] KIND_SPS     = 3'd1;
    localparam logic [2:0] KIND_PPS     = 3'd2;
    localparam logic [2:0] KIND_SKIP    = 3'd3;
    localparam logic [2:0] KIND_IGNORED = 3'd4;

    // header byte positions
    localparam logic [2:0] HDR_VERSION = 3'd0;
    localparam logic [2:0] HDR_PROFILE = 3'd1;
    localparam logic [2:0] HDR_COMPAT  = 3'd2;
    localparam logic [2:0] HDR_LEVEL   = 3'd3;
    localparam logic [2:0] HDR_LENSIZE = 3'd4;

    // reserved marker bits
    localparam logic [5:0] MARK_LENSIZE = 6'h3F;
    localparam logic [2:0] MARK_SPSCNT  = 3'h7;

    // result item, before packing onto the output stream
    typedef struct packed {
        logic [2:0]  byte_kind;
        logic [7:0]  out_byte;
        logic        unit_end;
        logic [15:0] unit_length;
        logic        record_done;
        logic        marker_error;
        logic [7:0]  version_out;
        logic [7:0]  profile_out;
        logic [7:0]  compat_out;
        logic [7:0]  level_out;
        logic [2:0]  nal_length_size;
    } t_result;

endpackage

@@ design/avc_config_record_parser_unit.sv @@
// Channel  | Dir | Signals         | Content (lowest bit first)
// ---------+-----+-----------------+----------------------------------------------
// in       | in  | s_axis_t*       | tdata: in_byte[7:0]; tuser: record_start
// out      | out | m_axis_t*       | tdata: out_byte, unit_length, marker_error,
//          |     |                 |   version, profile, compat, level,
//          |     |                 |   nal_length_size, 4 pad bits
//          |     |                 | tuser: byte_kind[2:0], unit_end; tlast: done
//
// One item per cycle unless the output stalls; each item's result is registered
// and appears in the cycle after it is accepted, set by the single parser state
// update feeding the result register. Synchronous active-low reset returns the
// parser to idle and empties the result register. A stalled result holds; a new
// item is still taken in the cycle the waiting one is drained.
module avc_config_record_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tuser,   // [0] record_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [7:0] out_byte, [23:8] unit_length,
                                        // [24] marker_error, [32:25] version,
                                        // [40:33] profile, [48:41] compat,
                                        // [56:49] level, [59:57] nal_length_size
    output logic [3:0]  m_axis_tuser,   // [2:0] byte_kind, [3] unit_end
    output logic        m_axis_tlast    // record_done
);

    // parser state
    logic [3:0]  r_phase,    n_phase;
    logic [2:0]  r_hdr_idx,  n_hdr_idx;
    logic [4:0]  r_sps_rem,  n_sps_rem;
    logic [7:0]  r_pps_rem,  n_pps_rem;
    logic [7:0]  r_len_hi,   n_len_hi;
    logic [15:0] r_byte_rem, n_byte_rem;
    logic [15:0] r_cur_len,  n_cur_len;
    logic        r_first,    n_first;
    logic [7:0]  r_version,  n_version;
    logic [7:0]  r_profile,  n_profile;
    logic [7:0]  r_compat,   n_compat;
    logic [7:0]  r_level,    n_level;
    logic [2:0]  r_len_size, n_len_size;
    logic        r_error,    n_error;

    // result register
    logic                 r_out_valid;
    acrp_pkg::t_result    r_res, n_res;

    logic        accept;
    logic [7:0]  b;
    logic [2:0]  kind;
    logic        uend;
    logic        done;
    logic        in_sps;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;

    always_comb begin
        n_phase    = r_phase;
        n_hdr_idx  = r_hdr_idx;
        n_sps_rem  = r_sps_rem;
        n_pps_rem  = r_pps_rem;
        n_len_hi   = r_len_hi;
        n_byte_rem = r_byte_rem;
        n_cur_len  = r_cur_len;
        n_first    = r_first;
        n_version  = r_version;
        n_profile  = r_profile;
        n_compat   = r_compat;
        n_level    = r_level;
        n_len_size = r_len_size;
        n_error    = r_error;
        kind       = acrp_pkg::KIND_HDR;
        uend       = 1'b0;
        done       = 1'b0;
        in_sps     = 1'b0;

        // record start discards any parse in progress
        if (s_axis_tuser) begin
            n_phase    = acrp_pkg::PH_HEADER;
            n_hdr_idx  = 3'd0;
            n_sps_rem  = 5'd0;
            n_pps_rem  = 8'd0;
            n_len_hi   = 8'd0;
            n_byte_rem = 16'd0;
            n_cur_len  = 16'd0;
            n_first    = 1'b1;
            n_version  = 8'd0;
            n_profile  = 8'd0;
            n_compat   = 8'd0;
            n_level    = 8'd0;
            n_len_size = 3'd1;
            n_error    = 1'b0;
        end

        unique case (n_phase)
            acrp_pkg::PH_HEADER: begin
                unique case (n_hdr_idx)
                    acrp_pkg::HDR_VERSION: n_version = b;
                    acrp_pkg::HDR_PROFILE: n_profile = b;
                    acrp_pkg::HDR_COMPAT:  n_compat  = b;
                    acrp_pkg::HDR_LEVEL:   n_level   = b;
                    acrp_pkg::HDR_LENSIZE: begin
                        if (b[7:2] != acrp_pkg::MARK_LENSIZE) n_error = 1'b1;
                        n_len_size = {1'b0, b[1:0]} + 3'd1;
                    end
                    default: begin
                        // SPS count byte
                        if (b[7:5] != acrp_pkg::MARK_SPSCNT) n_error = 1'b1;
                        n_sps_rem = b[4:0];
                        n_first   = 1'b1;
                        n_phase   = (b[4:0] == 5'd0) ? acrp_pkg::PH_PPS_CNT
                                                     : acrp_pkg::PH_SPS_HI;
                    end
                endcase
                n_hdr_idx = n_hdr_idx + 3'd1;
            end
            acrp_pkg::PH_SPS_HI, acrp_pkg::PH_PPS_HI: begin
                n_len_hi = b;
                n_phase  = n_phase + 4'd1;
            end
            acrp_pkg::PH_SPS_LO, acrp_pkg::PH_PPS_LO: begin
                in_sps    = (n_phase == acrp_pkg::PH_SPS_LO);
                n_cur_len = {n_len_hi, b};
                if ({n_len_hi, b} == 16'd0) begin
                    // empty unit closes at its low length byte
                    uend    = n_first;
                    n_first = 1'b0;
                    if (in_sps) begin
                        n_sps_rem = n_sps_rem - 5'd1;
                        n_phase   = (n_sps_rem == 5'd0) ? acrp_pkg::PH_PPS_CNT
                                                        : acrp_pkg::PH_SPS_HI;
                    end else begin
                        n_pps_rem = n_pps_rem - 8'd1;
                        done      = (n_pps_rem == 8'd0);
                        n_phase   = done ? acrp_pkg::PH_DONE : acrp_pkg::PH_PPS_HI;
                    end
                end else begin
                    n_byte_rem = {n_len_hi, b};
                    n_phase    = n_phase + 4'd1;
                end
            end
            acrp_pkg::PH_SPS_PAY, acrp_pkg::PH_PPS_PAY: begin
                in_sps = (n_phase == acrp_pkg::PH_SPS_PAY);
                if (n_first) begin
                    kind = in_sps ? acrp_pkg::KIND_SPS : acrp_pkg::KIND_PPS;
                end else begin
                    kind = acrp_pkg::KIND_SKIP;
                end
                n_byte_rem = n_byte_rem - 16'd1;
                if (n_byte_rem == 16'd0) begin
                    uend    = n_first;
                    n_first = 1'b0;
                    if (in_sps) begin
                        n_sps_rem = n_sps_rem - 5'd1;
                        n_phase   = (n_sps_rem == 5'd0) ? acrp_pkg::PH_PPS_CNT
                                                        : acrp_pkg::PH_SPS_HI;
                    end else begin
                        n_pps_rem = n_pps_rem - 8'd1;
                        done      = (n_pps_rem == 8'd0);
                        n_phase   = done ? acrp_pkg::PH_DONE : acrp_pkg::PH_PPS_HI;
                    end
                end
            end
            acrp_pkg::PH_PPS_CNT: begin
                n_pps_rem = b;
                n_first   = 1'b1;
                done      = (b == 8'd0);
                n_phase   = done ? acrp_pkg::PH_DONE : acrp_pkg::PH_PPS_HI;
            end
            default: begin
                // idle or past the end: byte ignored
                kind = acrp_pkg::KIND_IGNORED;
            end
        endcase

        n_res.byte_kind       = kind;
        n_res.out_byte        = b;
        n_res.unit_end        = uend;
        n_res.unit_length     = n_cur_len;
        n_res.record_done     = done;
        n_res.marker_error    = n_error;
        n_res.version_out     = n_version;
        n_res.profile_out     = n_profile;
        n_res.compat_out      = n_compat;
        n_res.level_out       = n_level;
        n_res.nal_length_size = n_len_size;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= acrp_pkg::PH_IDLE;
            r_hdr_idx   <= 3'd0;
            r_sps_rem   <= 5'd0;
            r_pps_rem   <= 8'd0;
            r_len_hi    <= 8'd0;
            r_byte_rem  <= 16'd0;
            r_cur_len   <= 16'd0;
            r_first     <= 1'b1;
            r_version   <= 8'd0;
            r_profile   <= 8'd0;
            r_compat    <= 8'd0;
            r_level     <= 8'd0;
            r_len_size  <= 3'd1;
            r_error     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase    <= n_phase;
                r_hdr_idx  <= n_hdr_idx;
                r_sps_rem  <= n_sps_rem;
                r_pps_rem  <= n_pps_rem;
                r_len_hi   <= n_len_hi;
                r_byte_rem <= n_byte_rem;
                r_cur_len  <= n_cur_len;
                r_first    <= n_first;
                r_version  <= n_version;
                r_profile  <= n_profile;
                r_compat   <= n_compat;
                r_level    <= n_level;
                r_len_size <= n_len_size;
                r_error    <= n_error;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_res.nal_length_size, r_res.level_out,
                            r_res.compat_out, r_res.profile_out, r_res.version_out,
                            r_res.marker_error, r_res.unit_length, r_res.out_byte};
    assign m_axis_tuser  = {r_res.unit_end, r_res.byte_kind};
    assign m_axis_tlast  = r_res.record_done;

endmodule

@@ test/avc_config_record_parser_unit_tb.sv @@
module avc_config_record_parser_unit_tb;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PRINT_LIMIT = 50;
    localparam int RANDOM_ITEMS = 1000;

    // one stimulus item plus its pacing controls
    typedef struct {
        logic [7:0] data;
        logic       start;
        bit         quiet;   // no gap after this item
        bit         hold;    // wait for every awaited result before sending
    } t_send_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] in_byte
    logic        s_axis_tuser = 1'b0;   // [0] record_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;          // out_byte, unit_length, marker_error, version,
                                        // profile, compat, level, nal_length_size, pad
    logic [3:0]  m_axis_tuser;          // byte_kind[2:0], unit_end
    logic        m_axis_tlast;          // record_done

    avc_config_record_parser_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_send_item         bytes_to_send[$];
    acrp_pkg::t_result  parse_results_due[$];
    logic [7:0]  rec_bytes[$];      // record under construction
    bit          must_cut;          // record too long or malformed: truncate it

    int          cycle_count = 0;
    int          mismatch_count = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    logic        in_fire = 1'b0;
    t_send_item  next_item;

    // parser state as seen by the predictor
    logic [3:0]  phase;
    logic [2:0]  hdr_idx;
    logic [4:0]  sps_left;
    logic [7:0]  pps_left;
    logic [7:0]  len_hi;
    logic [15:0] pay_left;
    logic [15:0] cur_len;
    logic        first_unit;
    logic [7:0]  cap_version;
    logic [7:0]  cap_profile;
    logic [7:0]  cap_compat;
    logic [7:0]  cap_level;
    logic [2:0]  cap_len_size;
    logic        marker_err;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic clear_parser();
        phase        = acrp_pkg::PH_IDLE;
        hdr_idx      = 3'd0;
        sps_left     = 5'd0;
        pps_left     = 8'd0;
        len_hi       = 8'd0;
        pay_left     = 16'd0;
        cur_len      = 16'd0;
        first_unit   = 1'b1;
        cap_version  = 8'd0;
        cap_profile  = 8'd0;
        cap_compat   = 8'd0;
        cap_level    = 8'd0;
        cap_len_size = 3'd1;
        marker_err   = 1'b0;
    endtask

    // one unit of the current list is over; a finished PPS list ends the record
    task automatic close_unit(input logic in_sps, output logic rec_end);
        rec_end = 1'b0;
        first_unit = 1'b0;
        if (in_sps) begin
            sps_left = sps_left - 5'd1;
            phase = (sps_left == 5'd0) ? acrp_pkg::PH_PPS_CNT : acrp_pkg::PH_SPS_HI;
        end else begin
            pps_left = pps_left - 8'd1;
            if (pps_left == 8'd0) begin
                phase = acrp_pkg::PH_DONE;
                rec_end = 1'b1;
            end else begin
                phase = acrp_pkg::PH_PPS_HI;
            end
        end
    endtask

    task automatic parse_record_byte(input logic [7:0] b, input logic start);
        acrp_pkg::t_result r;
        logic [2:0] kind;
        logic       uend;
        logic       rec_end;
        kind = acrp_pkg::KIND_HDR;
        uend = 1'b0;
        rec_end = 1'b0;
        // a start marker throws away whatever parse was in progress
        if (start) begin
            clear_parser();
            phase = acrp_pkg::PH_HEADER;
        end
        case (phase)
            acrp_pkg::PH_HEADER: begin
                case (hdr_idx)
                    acrp_pkg::HDR_VERSION: cap_version = b;
                    acrp_pkg::HDR_PROFILE: cap_profile = b;
                    acrp_pkg::HDR_COMPAT:  cap_compat = b;
                    acrp_pkg::HDR_LEVEL:   cap_level = b;
                    acrp_pkg::HDR_LENSIZE: begin
                        if (b[7:2] != acrp_pkg::MARK_LENSIZE) marker_err = 1'b1;
                        cap_len_size = {1'b0, b[1:0]} + 3'd1;
                    end
                    default: begin
                        if (b[7:5] != acrp_pkg::MARK_SPSCNT) marker_err = 1'b1;
                        sps_left = b[4:0];
                        first_unit = 1'b1;
                        phase = (sps_left == 5'd0) ? acrp_pkg::PH_PPS_CNT
                                                   : acrp_pkg::PH_SPS_HI;
                    end
                endcase
                hdr_idx = hdr_idx + 3'd1;
            end
            acrp_pkg::PH_SPS_HI, acrp_pkg::PH_PPS_HI: begin
                len_hi = b;
                phase = phase + 4'd1;
            end
            acrp_pkg::PH_SPS_LO, acrp_pkg::PH_PPS_LO: begin
                cur_len = {len_hi, b};
                if (cur_len == 16'd0) begin
                    // empty unit closes at its low length byte
                    uend = first_unit;
                    close_unit(phase == acrp_pkg::PH_SPS_LO, rec_end);
                end else begin
                    pay_left = cur_len;
                    phase = phase + 4'd1;
                end
            end
            acrp_pkg::PH_SPS_PAY, acrp_pkg::PH_PPS_PAY: begin
                if (first_unit)
                    kind = (phase == acrp_pkg::PH_SPS_PAY) ? acrp_pkg::KIND_SPS
                                                           : acrp_pkg::KIND_PPS;
                else
                    kind = acrp_pkg::KIND_SKIP;
                pay_left = pay_left - 16'd1;
                if (pay_left == 16'd0) begin
                    uend = first_unit;
                    close_unit(phase == acrp_pkg::PH_SPS_PAY, rec_end);
                end
            end
            acrp_pkg::PH_PPS_CNT: begin
                pps_left = b;
                first_unit = 1'b1;
                if (pps_left == 8'd0) begin
                    phase = acrp_pkg::PH_DONE;
                    rec_end = 1'b1;
                end else begin
                    phase = acrp_pkg::PH_PPS_HI;
                end
            end
            default: kind = acrp_pkg::KIND_IGNORED;   // idle or past the end
        endcase
        r.byte_kind       = kind;
        r.out_byte        = b;
        r.unit_end        = uend;
        r.unit_length     = cur_len;
        r.record_done     = rec_end;
        r.marker_error    = marker_err;
        r.version_out     = cap_version;
        r.profile_out     = cap_profile;
        r.compat_out      = cap_compat;
        r.level_out       = cap_level;
        r.nal_length_size = cap_len_size;
        parse_results_due.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch, cycle %0d: %s", cycle_count, what);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
            report_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
    endtask

    task automatic check_result();
        acrp_pkg::t_result want;
        if (parse_results_due.size() == 0) begin
            report_mismatch("result item with nothing awaited");
        end else begin
            want = parse_results_due.pop_front();
            check_field("byte_kind", 16'(want.byte_kind), 16'(m_axis_tuser[2:0]));
            check_field("unit_end", 16'(want.unit_end), 16'(m_axis_tuser[3]));
            check_field("record_done", 16'(want.record_done), 16'(m_axis_tlast));
            check_field("out_byte", 16'(want.out_byte), 16'(m_axis_tdata[7:0]));
            check_field("unit_length", want.unit_length, m_axis_tdata[23:8]);
            check_field("marker_error", 16'(want.marker_error), 16'(m_axis_tdata[24]));
            check_field("version", 16'(want.version_out), 16'(m_axis_tdata[32:25]));
            check_field("profile", 16'(want.profile_out), 16'(m_axis_tdata[40:33]));
            check_field("compat", 16'(want.compat_out), 16'(m_axis_tdata[48:41]));
            check_field("level", 16'(want.level_out), 16'(m_axis_tdata[56:49]));
            check_field("nal_length_size", 16'(want.nal_length_size),
                        16'(m_axis_tdata[59:57]));
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic start,
                             input bit quiet, input bit hold);
        t_send_item it;
        it.data = b;
        it.start = start;
        it.quiet = quiet;
        it.hold = hold;
        bytes_to_send.push_back(it);
    endtask

    function automatic logic [15:0] pick_len(input bit wild);
        int r;
        r = $urandom_range(0, 99);
        if (wild) return 16'($urandom);
        if (r < 20) return 16'd0;
        if (r < 90) return 16'($urandom_range(1, 6));
        return 16'($urandom_range(7, 40));
    endfunction

    // length bytes then payload; very long units are cut short later anyway
    task automatic push_unit(input logic [15:0] len);
        rec_bytes.push_back(len[15:8]);
        rec_bytes.push_back(len[7:0]);
        if (len > 16'd40) must_cut = 1'b1;
        for (int i = 0; i < int'(len) && i < 80; i++)
            rec_bytes.push_back(8'($urandom));
    endtask

    // wild: random marker bytes, counts and lengths, truncated at a random point
    task automatic emit_record(input bit wild, input bit force_hold);
        logic [7:0] cnt_byte;
        int         n_pps;
        int         cut;
        bit         quiet;
        bit         hold;
        rec_bytes.delete();
        must_cut = wild;
        quiet = ($urandom_range(0, 4) == 0);
        hold = force_hold || ($urandom_range(0, 19) == 0);
        repeat (4) rec_bytes.push_back(8'($urandom));
        if (wild) begin
            rec_bytes.push_back(8'($urandom));
            cnt_byte = 8'($urandom);
        end else begin
            rec_bytes.push_back({acrp_pkg::MARK_LENSIZE, 2'($urandom)});
            cnt_byte = {acrp_pkg::MARK_SPSCNT, ($urandom_range(0, 9) == 0) ?
                        5'($urandom) : 5'($urandom_range(0, 3))};
        end
        rec_bytes.push_back(cnt_byte);
        if (cnt_byte[4:0] > 5'd8) must_cut = 1'b1;
        for (int i = 0; i < int'(cnt_byte[4:0]) && rec_bytes.size() < 200; i++)
            push_unit(pick_len(wild && $urandom_range(0, 1) == 1));
        if (wild || $urandom_range(0, 9) == 0)
            n_pps = $urandom_range(0, 255);
        else
            n_pps = $urandom_range(0, 3);
        rec_bytes.push_back(8'(n_pps));
        if (n_pps > 8) must_cut = 1'b1;
        for (int i = 0; i < n_pps && rec_bytes.size() < 200; i++)
            push_unit(pick_len(wild && $urandom_range(0, 1) == 1));
        // a few bytes past the end, which the parser ignores
        if (!must_cut)
            repeat ($urandom_range(0, 2)) rec_bytes.push_back(8'($urandom));
        cut = rec_bytes.size();
        if (must_cut)
            cut = $urandom_range(1, (cut < 60) ? cut : 60);
        for (int i = 0; i < cut; i++)
            push_byte(rec_bytes[i], i == 0, quiet, hold && i == 0);
    endtask

    // ------------------------------------------------------------------
    // Sender: next item presented at the falling edge once the slot frees
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_fire) begin
            if (gap_left != 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (bytes_to_send.size() != 0 &&
                         !(bytes_to_send[0].hold && parse_results_due.size() != 0)) begin
                next_item = bytes_to_send.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= next_item.data;
                s_axis_tuser <= next_item.start;
                gap_left <= next_item.quiet ? 0 : pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, with a quiet stretch every fourth window
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (cycle_count[9:8] != 2'b11 && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    // Monitor: results checked before the item taken at this edge is predicted
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                parse_record_byte(s_axis_tdata, s_axis_tuser);
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Run
    // ------------------------------------------------------------------
    initial begin
        int r;
        clear_parser();

        // stray byte before any record
        push_byte(8'h00, 1'b0, 1'b0, 1'b0);
        // both lists empty: record ends at the PPS count
        push_byte(8'hFF, 1'b1, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0, 1'b0);
        push_byte(8'hAA, 1'b0, 1'b0, 1'b0);
        push_byte(8'h55, 1'b0, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0, 1'b0);
        push_byte(8'hE0, 1'b0, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0, 1'b0);
        // bad markers in both bytes, max length, then a restart mid record
        push_byte(8'h01, 1'b1, 1'b0, 1'b0);
        push_byte(8'h80, 1'b0, 1'b0, 1'b0);
        push_byte(8'h40, 1'b0, 1'b0, 1'b0);
        push_byte(8'h1E, 1'b0, 1'b0, 1'b0);
        push_byte(8'h03, 1'b0, 1'b0, 1'b0);
        push_byte(8'h21, 1'b0, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0, 1'b0);
        // empty first SPS, one-byte first PPS, empty skipped PPS, one byte past end
        push_byte(8'h01, 1'b1, 1'b0, 1'b1);
        push_byte(8'h64, 1'b0, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0, 1'b0);
        push_byte(8'h28, 1'b0, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0, 1'b0);
        push_byte(8'hE1, 1'b0, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0, 1'b0);
        push_byte(8'h02, 1'b0, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0, 1'b0);
        push_byte(8'h01, 1'b0, 1'b0, 1'b0);
        push_byte(8'h77, 1'b0, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0, 1'b0);
        push_byte(8'h3C, 1'b0, 1'b0, 1'b0);

        // random part: mostly well-formed records, some broken ones, some noise
        emit_record(1'b0, 1'b1);
        while (bytes_to_send.size() < RANDOM_ITEMS + 30) begin
            r = $urandom_range(0, 99);
            if (r < 75)
                emit_record(1'b0, 1'b0);
            else if (r < 88)
                emit_record(1'b1, 1'b0);
            else
                repeat ($urandom_range(1, 4))
                    push_byte(8'($urandom), $urandom_range(0, 7) == 0, 1'b0, 1'b0);
        end

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_to_send.size() != 0 || s_axis_tvalid) @(negedge i_clk);
        while (parse_results_due.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
design/acrp_pkg.sv
design/avc_config_record_parser_unit.sv
test/avc_config_record_parser_unit_tb.sv
